[hdl/fcpr_pkg.sv]
// ----------------------------------------------------------------------------
// fcpr_pkg
// Shared types and constants of the framed command packet receiver.
// ----------------------------------------------------------------------------
package fcpr_pkg;

  localparam int PAYLOAD_MAX = 4;
  localparam int ALARM_SLOTS = 2;
  localparam int CMD_COUNT   = 4;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = $clog2(PAYLOAD_MAX + 1);
  localparam int IDX_W   = $clog2(PAYLOAD_MAX);
  localparam int SLOT_W  = $clog2(ALARM_SLOTS);
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int COLOR_W = 16;
  localparam int TEMPO_W = 32;
  localparam int PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CMD   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;

  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COLOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEMPO = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ALARM = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COLOR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEMPO = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ALARM = 2'd3;

  localparam logic [CNT_W-1:0] COLOR_LEN = CNT_W'(2);
  localparam logic [CNT_W-1:0] TEMPO_LEN = CNT_W'(4);
  localparam logic [CNT_W-1:0] ALARM_LEN = CNT_W'(2);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START = 1'd1;

  localparam logic [BYTE_W-1:0] FIRST_START_RESET  = 8'd42;
  localparam logic [BYTE_W-1:0] SECOND_START_RESET = 8'd126;

  typedef logic [PAYLOAD_MAX-1:0][BYTE_W-1:0] payload_t;

  typedef struct packed {
    logic             done;
    logic [CMD_W-1:0] command;
    logic [CNT_W-1:0] length;
    payload_t         payload;
  } packet_t;

  typedef struct packed {
    logic [KIND_W-1:0]  update_kind;
    logic [COLOR_W-1:0] light_color;
    logic [TEMPO_W-1:0] tempo_scaled;
    logic [BYTE_W-1:0]  alarm_level_zero;
    logic [BYTE_W-1:0]  alarm_level_one;
  } result_t;

endpackage

[hdl/fcpr_if.sv]
// ----------------------------------------------------------------------------
// fcpr_if
// Valid/ready channels of the receiver: received bytes in, results out.
// ----------------------------------------------------------------------------
interface fcpr_in_if;
  logic                        valid;
  logic                        ready;
  logic [fcpr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcpr_out_if;
  logic                         valid;
  logic                         ready;
  logic [fcpr_pkg::KIND_W-1:0]  update_kind;
  logic                         frame_reject;
  logic [fcpr_pkg::COLOR_W-1:0] light_color;
  logic [fcpr_pkg::TEMPO_W-1:0] tempo_scaled;
  logic [fcpr_pkg::BYTE_W-1:0]  alarm_level_zero;
  logic [fcpr_pkg::BYTE_W-1:0]  alarm_level_one;

  modport source (output valid, output update_kind, output frame_reject,
                  output light_color, output tempo_scaled,
                  output alarm_level_zero, output alarm_level_one, input ready);
  modport sink   (input valid, input update_kind, input frame_reject,
                  input light_color, input tempo_scaled,
                  input alarm_level_zero, input alarm_level_one, output ready);
endinterface

[hdl/fcpr_parser.sv]
// ----------------------------------------------------------------------------
// fcpr_parser
// Packet framing state machine and payload capture.
// ----------------------------------------------------------------------------
module fcpr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [fcpr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [fcpr_pkg::BYTE_W-1:0] first_start,
  input  logic [fcpr_pkg::BYTE_W-1:0] second_start,
  output fcpr_pkg::packet_t           pkt,
  output logic                        reject
);

  logic [fcpr_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [fcpr_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [fcpr_pkg::CNT_W-1:0]   len_r, len_nxt;
  logic [fcpr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  fcpr_pkg::payload_t           payload_r, payload_nxt;

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    payload_nxt = payload_r;
    reject      = 1'b0;
    unique case (phase_r)
      fcpr_pkg::PH_HUNT2: begin
        if (rx_byte == second_start) begin
          phase_nxt = fcpr_pkg::PH_CMD;
        end else begin
          phase_nxt = fcpr_pkg::PH_HUNT1;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          reject    = 1'b1;
        end
      end
      fcpr_pkg::PH_CMD: begin
        if (rx_byte < fcpr_pkg::BYTE_W'(fcpr_pkg::CMD_COUNT)) begin
          cmd_nxt   = rx_byte[fcpr_pkg::CMD_W-1:0];
          phase_nxt = fcpr_pkg::PH_LEN;
        end else begin
          phase_nxt = fcpr_pkg::PH_HUNT1;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          reject    = 1'b1;
        end
      end
      fcpr_pkg::PH_LEN: begin
        if (rx_byte <= fcpr_pkg::BYTE_W'(fcpr_pkg::PAYLOAD_MAX)) begin
          len_nxt   = rx_byte[fcpr_pkg::CNT_W-1:0];
          cnt_nxt   = '0;
          phase_nxt = fcpr_pkg::PH_DATA;
        end else begin
          phase_nxt = fcpr_pkg::PH_HUNT1;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          reject    = 1'b1;
        end
      end
      fcpr_pkg::PH_DATA: begin
        if (len_r != '0 && cnt_r < fcpr_pkg::CNT_W'(fcpr_pkg::PAYLOAD_MAX)) begin
          payload_nxt[cnt_r[fcpr_pkg::IDX_W-1:0]] = rx_byte;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cnt_nxt >= len_r) begin
          phase_nxt = fcpr_pkg::PH_HUNT1;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = (rx_byte == first_start) ? fcpr_pkg::PH_HUNT2 : fcpr_pkg::PH_HUNT1;
      end
    endcase
  end

  // The packet is complete when the data phase hands control back to hunting.
  always_comb begin
    pkt.done    = (phase_r == fcpr_pkg::PH_DATA) && (phase_nxt == fcpr_pkg::PH_HUNT1);
    pkt.command = cmd_r;
    pkt.length  = len_r;
    pkt.payload = payload_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fcpr_pkg::PH_HUNT1;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      payload_r <= payload_nxt;
    end
  end

endmodule

[hdl/fcpr_stores.sv]
// ----------------------------------------------------------------------------
// fcpr_stores
// Applies completed packets to the light colour, tempo and alarm stores.
// ----------------------------------------------------------------------------
module fcpr_stores (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  fcpr_pkg::packet_t pkt,
  output fcpr_pkg::result_t result
);

  logic [fcpr_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic [fcpr_pkg::TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [fcpr_pkg::ALARM_SLOTS-1:0][fcpr_pkg::BYTE_W-1:0] alarm_r, alarm_nxt;
  logic [fcpr_pkg::KIND_W-1:0]  kind;

  always_comb begin
    color_nxt = color_r;
    tempo_nxt = tempo_r;
    alarm_nxt = alarm_r;
    kind      = fcpr_pkg::KIND_NONE;
    if (pkt.done) begin
      unique case (pkt.command)
        fcpr_pkg::CMD_COLOR: begin
          if (pkt.length == fcpr_pkg::COLOR_LEN) begin
            color_nxt = {pkt.payload[1], pkt.payload[0]};
            kind      = fcpr_pkg::KIND_COLOR;
          end
        end
        fcpr_pkg::CMD_TEMPO: begin
          if (pkt.length == fcpr_pkg::TEMPO_LEN) begin
            tempo_nxt = {pkt.payload[3], pkt.payload[2], pkt.payload[1], pkt.payload[0]};
            kind      = fcpr_pkg::KIND_TEMPO;
          end
        end
        fcpr_pkg::CMD_ALARM: begin
          if (pkt.length == fcpr_pkg::ALARM_LEN &&
              pkt.payload[0] < fcpr_pkg::BYTE_W'(fcpr_pkg::ALARM_SLOTS)) begin
            alarm_nxt[pkt.payload[0][fcpr_pkg::SLOT_W-1:0]] = pkt.payload[1];
            kind = fcpr_pkg::KIND_ALARM;
          end
        end
        default: begin
          kind = fcpr_pkg::KIND_NONE;
        end
      endcase
    end
  end

  always_comb begin
    result.update_kind      = kind;
    result.light_color      = color_nxt;
    result.tempo_scaled     = tempo_nxt;
    result.alarm_level_zero = alarm_nxt[0];
    result.alarm_level_one  = alarm_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
      tempo_r <= '0;
      alarm_r <= '0;
    end else if (fire) begin
      color_r <= color_nxt;
      tempo_r <= tempo_nxt;
      alarm_r <= alarm_nxt;
    end
  end

endmodule

[hdl/framed_command_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// framed_command_packet_receiver_unit
// Start-byte framed, length-prefixed command packet receiver.
// ----------------------------------------------------------------------------
// Each accepted word is one received byte and produces exactly one result
// word, which shows the update applied by that byte, whether it abandoned a
// partial packet, and the stores as they stand after it. The unit takes one
// byte per clock cycle while the output is not stalled; a byte passes through
// an input register and then a result register before its result is offered,
// and while a result waits the input accepts a byte only into an empty input
// register. The user must write the two start bytes on the configuration port
// only while no bytes are in flight; the unit does not enforce this.
module framed_command_packet_receiver_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  fcpr_in_if.sink                        in_chan,
  fcpr_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [fcpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcpr_pkg::BYTE_W-1:0]    cfg_data
);

  logic [fcpr_pkg::BYTE_W-1:0] first_start_r;
  logic [fcpr_pkg::BYTE_W-1:0] second_start_r;
  logic                        in_valid_r;
  logic [fcpr_pkg::BYTE_W-1:0] in_byte_r;
  logic                        out_valid_r;
  fcpr_pkg::result_t           result_r;
  logic                        reject_r;
  logic                        out_free;
  logic                        fire;
  fcpr_pkg::packet_t           pkt;
  fcpr_pkg::result_t           result;
  logic                        reject;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign fire          = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_start_r  <= fcpr_pkg::FIRST_START_RESET;
      second_start_r <= fcpr_pkg::SECOND_START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcpr_pkg::CFG_FIRST_START:  first_start_r  <= cfg_data;
        fcpr_pkg::CFG_SECOND_START: second_start_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
    if (fire) begin
      result_r <= result;
      reject_r <= reject;
    end
  end

  fcpr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .rx_byte      (in_byte_r),
    .first_start  (first_start_r),
    .second_start (second_start_r),
    .pkt          (pkt),
    .reject       (reject)
  );

  fcpr_stores u_stores (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .pkt    (pkt),
    .result (result)
  );

  assign out_chan.valid            = out_valid_r;
  assign out_chan.update_kind      = result_r.update_kind;
  assign out_chan.frame_reject     = reject_r;
  assign out_chan.light_color      = result_r.light_color;
  assign out_chan.tempo_scaled     = result_r.tempo_scaled;
  assign out_chan.alarm_level_zero = result_r.alarm_level_zero;
  assign out_chan.alarm_level_one  = result_r.alarm_level_one;

endmodule
